/* src/ssce_pkg.sv */
// ----------------------------------------------------------------------------
// ssce_pkg
// Shared types, widths and helpers of the synapse current engine.
// ----------------------------------------------------------------------------
`default_nettype none

package ssce_pkg;

  localparam int MAX_NEURONS_DEF = 64;
  localparam int CNT_W  = 7;
  localparam int IDX_W  = 6;
  localparam int MASK_W = 64;
  localparam int CUR_W  = 32;
  localparam int WGT_W  = 24;
  localparam int TAU_W  = 16;
  localparam int SUM_W  = 40;
  localparam int DIV_W  = 32;

  localparam logic [CNT_W-1:0] NCOUNT_RST = 7'd64;

  // Item actions
  typedef enum logic [1:0] {
    ACT_TICK   = 2'd0,
    ACT_LOAD   = 2'd1,
    ACT_UPDATE = 2'd2,
    ACT_BIAS   = 2'd3
  } action_t;

  // One synapse entry
  typedef struct packed {
    logic [CUR_W-1:0] cur;
    logic [WGT_W-1:0] weight;
    logic [TAU_W-1:0] tau;
    logic             conn;
  } syn_word_t;

  // One neuron entry
  typedef struct packed {
    logic [SUM_W-1:0] psum;
    logic [CUR_W-1:0] bias;
  } neu_word_t;

  // Saturate a 41-bit signed value to 32 bits
  function automatic logic [CUR_W-1:0] sat32(input logic [40:0] v);
    logic hi_ok;
    logic lo_ok;
    hi_ok = (v[40:31] == 10'h000);
    lo_ok = (v[40:31] == 10'h3FF);
    if (hi_ok || lo_ok) begin
      return v[31:0];
    end else if (v[40]) begin
      return 32'h8000_0000;
    end else begin
      return 32'h7FFF_FFFF;
    end
  endfunction

endpackage

`default_nettype wire

/* src/ssce_ram.sv */
// ----------------------------------------------------------------------------
// ssce_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module ssce_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* src/ssce_div.sv */
// ----------------------------------------------------------------------------
// ssce_div
// Radix-2 restoring divider: 32-bit dividend by 16-bit divisor, one bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ssce_div (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [ssce_pkg::DIV_W-1:0]   dividend,
  input  wire logic [ssce_pkg::TAU_W-1:0]   divisor,
  output logic                              done,
  output logic [ssce_pkg::DIV_W-1:0]        quotient,
  output logic                              rem_nz
);
  import ssce_pkg::*;

  localparam int CW = $clog2(DIV_W);

  logic [DIV_W-1:0] quo_r, quo_nxt;
  logic [TAU_W-1:0] rem_r, rem_nxt;
  logic [TAU_W-1:0] dvs_r, dvs_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [TAU_W:0]   trial;
  logic [TAU_W:0]   diff;

  // One quotient bit per cycle
  always_comb begin
    trial    = {rem_r, quo_r[DIV_W-1]};
    diff     = trial - {1'b0, dvs_r};
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = diff[TAU_W-1:0];
        quo_nxt = {quo_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[TAU_W-1:0];
        quo_nxt = {quo_r[DIV_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(DIV_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;
  assign rem_nz   = (rem_r != '0);

endmodule

`default_nettype wire

/* src/spike_synapse_current_engine_core.sv */
// ----------------------------------------------------------------------------
// spike_synapse_current_engine_core
// Synapse engine: per-pair weight, tau and current in one RAM, per-neuron
// partial sum and bias in a second RAM, tick walk with a shared divider.
// ----------------------------------------------------------------------------
// A write word is read in ST_WRD and written in ST_WWR. A tick walks every
// pre/post pair of the active neurons through ST_TRD and ST_TEX; a connected
// pair also waits in ST_TDIV for the 32-step decay divider. Then each active
// neuron is read and reported. Items are handled one at a time.
// Reset: synchronous, active low; afterwards a clearing pass sweeps the
// synapse RAM and the neuron RAM while no item is accepted.
`default_nettype none

module spike_synapse_current_engine_core #(
  parameter int MAX_NEURONS = ssce_pkg::MAX_NEURONS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // configuration
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [ssce_pkg::CNT_W-1:0]    cfg_data,
  // input items
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [1:0]                    in_action,
  input  wire logic [ssce_pkg::MASK_W-1:0]   in_spike_mask,
  input  wire logic [ssce_pkg::IDX_W-1:0]    in_pre_index,
  input  wire logic [ssce_pkg::IDX_W-1:0]    in_post_index,
  input  wire logic [ssce_pkg::WGT_W-1:0]    in_weight_value,
  input  wire logic [ssce_pkg::TAU_W-1:0]    in_decay_tau,
  input  wire logic [ssce_pkg::CUR_W-1:0]    in_bias_value,
  // results
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [ssce_pkg::IDX_W-1:0]         out_neuron_index,
  output logic [ssce_pkg::CUR_W-1:0]         out_total_current,
  output logic                               out_accepted,
  output logic                               out_last
);
  import ssce_pkg::*;

  localparam int NW   = $clog2(MAX_NEURONS);
  localparam int AW   = 2 * NW;
  localparam int SYNW = $bits(syn_word_t);
  localparam int NEUW = $bits(neu_word_t);

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_CLR  = 9'b000000010,
    ST_TRD  = 9'b000000100,
    ST_TEX  = 9'b000001000,
    ST_TDIV = 9'b000010000,
    ST_ORD  = 9'b000100000,
    ST_OWR  = 9'b001000000,
    ST_WRD  = 9'b010000000,
    ST_WWR  = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  logic [CNT_W-1:0]       ncount_r, ncount_nxt;
  logic [CNT_W-1:0]       n_act;
  logic [AW-1:0]          clr_r, clr_nxt;
  logic [NW-1:0]          i_r, i_nxt;
  logic [NW-1:0]          j_r, j_nxt;
  logic [MAX_NEURONS-1:0] mask_r, mask_nxt;
  action_t                act_r, act_nxt;
  logic [IDX_W-1:0]       pre_r, pre_nxt;
  logic [IDX_W-1:0]       post_r, post_nxt;
  logic [WGT_W-1:0]       w_r, w_nxt;
  logic [TAU_W-1:0]       tau_r, tau_nxt;
  logic [CUR_W-1:0]       bias_r, bias_nxt;
  logic                   sneg_r, sneg_nxt;
  logic [CUR_W-1:0]       abs_r, abs_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]       out_idx_r, out_idx_nxt;
  logic [CUR_W-1:0]       out_cur_r, out_cur_nxt;
  logic                   out_acc_r, out_acc_nxt;
  logic                   out_last_r, out_last_nxt;

  // memory ports
  logic            a_we, a_re, b_we, b_re;
  logic [AW-1:0]   a_waddr, a_raddr;
  logic [NW-1:0]   b_waddr, b_raddr;
  syn_word_t       a_wdata, a_rword;
  neu_word_t       b_wdata, b_rword;
  logic [SYNW-1:0] a_rdata;
  logic [NEUW-1:0] b_rdata;

  // divider
  logic             div_start, div_done, div_rem_nz;
  logic [DIV_W-1:0] div_quo;

  // datapath
  logic [32:0]      cur_w_sum;
  logic [CUR_W-1:0] s_fire, s_val, s_abs, mag, s_dec;
  logic [SUM_W-1:0] psum_new;
  logic [40:0]      tot;
  logic             out_free, in_acc, wr_in_range, wr_ok;
  logic             j_end, i_end;

  ssce_ram #(.WIDTH(SYNW), .DEPTH(2 ** AW)) u_syn_ram (
    .clk(clk), .we(a_we), .waddr(a_waddr), .wdata(a_wdata),
    .re(a_re), .raddr(a_raddr), .rdata(a_rdata)
  );

  ssce_ram #(.WIDTH(NEUW), .DEPTH(2 ** NW)) u_neu_ram (
    .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
    .re(b_re), .raddr(b_raddr), .rdata(b_rdata)
  );

  // dividend is the magnitude formed in the same cycle as the start pulse
  ssce_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(s_abs),
    .divisor(a_rword.tau), .done(div_done), .quotient(div_quo), .rem_nz(div_rem_nz)
  );

  assign a_rword = syn_word_t'(a_rdata);
  assign b_rword = neu_word_t'(b_rdata);

  // active neuron count, clamped
  always_comb begin
    if (ncount_r == '0) begin
      n_act = CNT_W'(1);
    end else if (ncount_r > CNT_W'(MAX_NEURONS)) begin
      n_act = CNT_W'(MAX_NEURONS);
    end else begin
      n_act = ncount_r;
    end
  end

  // synapse arithmetic: weight add, sum, decay magnitude
  always_comb begin
    cur_w_sum = {a_rword.cur[31], a_rword.cur} + {{9{a_rword.weight[WGT_W-1]}}, a_rword.weight};
    s_fire    = sat32({{8{cur_w_sum[32]}}, cur_w_sum});
    s_val     = mask_r[i_r] ? s_fire : a_rword.cur;
    psum_new  = b_rword.psum + {{8{s_val[31]}}, s_val};
    s_abs     = s_val[31] ? (~s_val + 1'b1) : s_val;
    // |s| - ceil(|s|/tau), sign restored
    mag       = abs_r - (div_quo + {31'd0, div_rem_nz});
    s_dec     = sneg_r ? (~mag + 1'b1) : mag;
    if (a_rword.tau == '0) begin
      s_dec = '0;
    end
    tot       = {b_rword.psum[39], b_rword.psum} + {{9{b_rword.bias[31]}}, b_rword.bias};
  end

  assign out_free    = !out_valid_r || !out_stall;
  assign in_acc      = in_valid && !in_stall;
  assign j_end       = ({1'b0, 6'(j_r)} == n_act - 1'b1);
  assign i_end       = ({1'b0, 6'(i_r)} == n_act - 1'b1);
  assign wr_in_range = ({1'b0, pre_r} < n_act) && ({1'b0, post_r} < n_act);

  always_comb begin
    unique case (act_r)
      ACT_LOAD:   wr_ok = wr_in_range && (tau_r >= TAU_W'(1));
      ACT_UPDATE: wr_ok = wr_in_range && (tau_r > TAU_W'(1));
      ACT_BIAS:   wr_ok = ({1'b0, post_r} < n_act);
      default:    wr_ok = 1'b0;
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    ncount_nxt    = ncount_r;
    clr_nxt       = clr_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    mask_nxt      = mask_r;
    act_nxt       = act_r;
    pre_nxt       = pre_r;
    post_nxt      = post_r;
    w_nxt         = w_r;
    tau_nxt       = tau_r;
    bias_nxt      = bias_r;
    sneg_nxt      = sneg_r;
    abs_nxt       = abs_r;
    out_idx_nxt   = out_idx_r;
    out_cur_nxt   = out_cur_r;
    out_acc_nxt   = out_acc_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_valid_r && out_stall;
    a_we          = 1'b0;
    a_waddr       = {i_r, j_r};
    a_wdata       = a_rword;
    a_re          = 1'b0;
    a_raddr       = {i_r, j_r};
    b_we          = 1'b0;
    b_waddr       = j_r;
    b_wdata       = b_rword;
    b_re          = 1'b0;
    b_raddr       = j_r;
    div_start     = 1'b0;

    if (cfg_valid) begin
      ncount_nxt = cfg_data;
    end

    unique case (state_r)
      ST_CLR: begin
        a_we    = 1'b1;
        a_waddr = clr_r;
        a_wdata = '{cur: '0, weight: '0, tau: TAU_W'(1), conn: 1'b0};
        b_we    = 1'b1;
        b_waddr = clr_r[NW-1:0];
        b_wdata = '0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == '1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          act_nxt  = action_t'(in_action);
          pre_nxt  = in_pre_index;
          post_nxt = in_post_index;
          w_nxt    = in_weight_value;
          tau_nxt  = in_decay_tau;
          bias_nxt = in_bias_value;
          mask_nxt = in_spike_mask[MAX_NEURONS-1:0];
          i_nxt    = '0;
          j_nxt    = '0;
          if (action_t'(in_action) == ACT_TICK) begin
            state_nxt = ST_TRD;
          end else begin
            state_nxt = ST_WRD;
          end
        end
      end
      ST_TRD: begin
        a_re      = 1'b1;
        b_re      = 1'b1;
        state_nxt = ST_TEX;
      end
      ST_TEX: begin
        if (a_rword.conn) begin
          b_we      = 1'b1;
          b_wdata   = '{psum: psum_new, bias: b_rword.bias};
          sneg_nxt  = s_val[31];
          abs_nxt   = s_abs;
          div_start = 1'b1;
          state_nxt = ST_TDIV;
        end else begin
          state_nxt = ST_TRD;
          j_nxt     = j_r + 1'b1;
          if (j_end) begin
            j_nxt = '0;
            i_nxt = i_r + 1'b1;
            if (i_end) begin
              state_nxt = ST_ORD;
            end
          end
        end
      end
      ST_TDIV: begin
        if (div_done) begin
          a_we      = 1'b1;
          a_wdata   = '{cur: s_dec, weight: a_rword.weight, tau: a_rword.tau, conn: 1'b1};
          state_nxt = ST_TRD;
          j_nxt     = j_r + 1'b1;
          if (j_end) begin
            j_nxt = '0;
            i_nxt = i_r + 1'b1;
            if (i_end) begin
              state_nxt = ST_ORD;
            end
          end
        end
      end
      ST_ORD: begin
        b_re      = 1'b1;
        state_nxt = ST_OWR;
      end
      ST_OWR: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_idx_nxt   = IDX_W'(j_r);
          out_cur_nxt   = sat32(tot);
          out_acc_nxt   = 1'b1;
          out_last_nxt  = j_end;
          // clear the partial sum for the next tick
          b_we          = 1'b1;
          b_wdata       = '{psum: '0, bias: b_rword.bias};
          j_nxt         = j_r + 1'b1;
          state_nxt     = j_end ? ST_IDLE : ST_ORD;
        end
      end
      ST_WRD: begin
        a_re      = 1'b1;
        a_raddr   = {pre_r[NW-1:0], post_r[NW-1:0]};
        state_nxt = ST_WWR;
      end
      ST_WWR: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_idx_nxt   = post_r;
          out_cur_nxt   = '0;
          out_acc_nxt   = wr_ok;
          out_last_nxt  = 1'b1;
          a_waddr       = {pre_r[NW-1:0], post_r[NW-1:0]};
          a_wdata       = '{cur: a_rword.cur, weight: w_r, tau: tau_r,
                            conn: a_rword.conn || (act_r == ACT_LOAD)};
          b_waddr       = post_r[NW-1:0];
          b_wdata       = '{psum: '0, bias: bias_r};
          if (wr_ok) begin
            if (act_r == ACT_BIAS) begin
              b_we = 1'b1;
            end else begin
              a_we = 1'b1;
            end
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      ncount_r    <= NCOUNT_RST;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ncount_r    <= ncount_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    mask_r     <= mask_nxt;
    act_r      <= act_nxt;
    pre_r      <= pre_nxt;
    post_r     <= post_nxt;
    w_r        <= w_nxt;
    tau_r      <= tau_nxt;
    bias_r     <= bias_nxt;
    sneg_r     <= sneg_nxt;
    abs_r      <= abs_nxt;
    out_idx_r  <= out_idx_nxt;
    out_cur_r  <= out_cur_nxt;
    out_acc_r  <= out_acc_nxt;
    out_last_r <= out_last_nxt;
  end

  assign cfg_ready         = 1'b1;
  assign in_stall          = (state_r != ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_neuron_index  = out_idx_r;
  assign out_total_current = out_cur_r;
  assign out_accepted      = out_acc_r;
  assign out_last          = out_last_r;

  // checks
  a_clr_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLR) |-> !out_valid_r)
    else $error("result word during clearing pass");

  a_div_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_TDIV))
    else $error("divider finished outside decay step");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_acc_r) |-> ({1'b0, out_idx_r} < n_act))
    else $error("accepted result reports neuron out of range");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OWR && !out_free) |=> (state_r == ST_OWR))
    else $error("tick report advanced while output was blocked");

endmodule

`default_nettype wire

/* tb/sv/spike_synapse_current_engine_core_test.sv */
// ----------------------------------------------------------------------------
// spike_synapse_current_engine_core_test
// Self-checking bench for the synapse current engine. A directed table and
// then random words are sent through the stall handshake, with bursty input
// and a stalling receiver. Results are checked against a behavioral model of
// the synapse state over several neuron counts.
// ----------------------------------------------------------------------------
`default_nettype none

module spike_synapse_current_engine_core_test;
  import ssce_pkg::*;

  localparam int NMAX = MAX_NEURONS_DEF;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int DRAIN_CYCLES = 64;

  typedef struct {
    action_t          act;
    logic [63:0]      mask;
    logic [IDX_W-1:0] pre;
    logic [IDX_W-1:0] post;
    logic [WGT_W-1:0] wgt;
    logic [TAU_W-1:0] tau;
    logic [CUR_W-1:0] bias;
    bit               chk;   // typed-in accept flag present
    bit               acc;
  } syn_item_t;

  typedef struct {
    logic [IDX_W-1:0] idx;
    logic [CUR_W-1:0] cur;
    logic             acc;
    logic             last;
  } neuron_report_t;

  logic clk;
  logic rst_n;
  logic cfg_valid, cfg_ready;
  logic [CNT_W-1:0] cfg_data;
  logic in_valid, in_stall;
  logic [1:0] in_action;
  logic [MASK_W-1:0] in_spike_mask;
  logic [IDX_W-1:0] in_pre_index, in_post_index;
  logic [WGT_W-1:0] in_weight_value;
  logic [TAU_W-1:0] in_decay_tau;
  logic [CUR_W-1:0] in_bias_value;
  logic out_valid, out_stall;
  logic [IDX_W-1:0] out_neuron_index;
  logic [CUR_W-1:0] out_total_current;
  logic out_accepted, out_last;

  spike_synapse_current_engine_core u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_action(in_action),
    .in_spike_mask(in_spike_mask), .in_pre_index(in_pre_index),
    .in_post_index(in_post_index), .in_weight_value(in_weight_value),
    .in_decay_tau(in_decay_tau), .in_bias_value(in_bias_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_neuron_index(out_neuron_index), .out_total_current(out_total_current),
    .out_accepted(out_accepted), .out_last(out_last)
  );

  // model state
  int           mdl_cur  [NMAX*NMAX];
  int           mdl_wgt  [NMAX*NMAX];
  int unsigned  mdl_tau  [NMAX*NMAX];
  bit           mdl_conn [NMAX*NMAX];
  int           mdl_bias [NMAX];
  logic [CNT_W-1:0] mdl_count;

  neuron_report_t report_q[$];
  int errors;
  int cycles;
  int burst_left;

  function automatic int unsigned active_n();
    if (mdl_count == 0) return 1;
    if (mdl_count > NMAX) return NMAX;
    return mdl_count;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // model one accepted word; returns the accept flag of a write
  function automatic bit predict_reports(syn_item_t it);
    int unsigned n;
    longint s, t;
    longint sums[NMAX];
    neuron_report_t r;
    int a;
    bit ok;
    n = active_n();
    ok = 1'b1;
    if (it.act == ACT_TICK) begin
      for (int j = 0; j < NMAX; j++) sums[j] = 0;
      for (int i = 0; i < n; i++) begin
        for (int j = 0; j < n; j++) begin
          a = i*NMAX + j;
          if (!mdl_conn[a]) continue;
          s = mdl_cur[a];
          if (it.mask[i]) s = clamp32(s + mdl_wgt[a]);
          sums[j] += s;
          t = mdl_tau[a];
          s = (t > 0) ? (s * (t - 1)) / t : 0;
          mdl_cur[a] = int'(s);
        end
      end
      for (int j = 0; j < n; j++) begin
        r.idx = IDX_W'(j);
        r.cur = 32'(clamp32(sums[j] + mdl_bias[j]));
        r.acc = 1'b1;
        r.last = (j == n - 1);
        report_q.push_back(r);
      end
      return 1'b1;
    end
    if (it.act == ACT_BIAS) begin
      ok = it.post < n;
      if (ok) mdl_bias[it.post] = $signed(it.bias);
    end else begin
      ok = (it.pre < n) && (it.post < n) &&
           ((it.act == ACT_LOAD) ? (it.tau >= 1) : (it.tau > 1));
      if (ok) begin
        a = it.pre*NMAX + it.post;
        mdl_wgt[a] = $signed(it.wgt);
        mdl_tau[a] = it.tau;
        if (it.act == ACT_LOAD) mdl_conn[a] = 1'b1;
      end
    end
    r.idx = it.post;
    r.cur = '0;
    r.acc = ok;
    r.last = 1'b1;
    report_q.push_back(r);
    return ok;
  endfunction

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // cycle watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // receiver stall pattern: quiet stretches, then choppy ones
  always @(posedge clk) begin
    if (cycles[10:9] == 2'd0) out_stall <= 1'b0;
    else if (cycles[10:9] == 2'd1) out_stall <= ($urandom_range(0, 3) == 0);
    else out_stall <= ($urandom_range(0, 9) < 6);
  end

  // result checker
  always @(posedge clk) begin
    neuron_report_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (report_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected word idx=%0d cur=%h", $time,
                 out_neuron_index, out_total_current);
      end else begin
        e = report_q.pop_front();
        if (out_neuron_index !== e.idx || out_total_current !== e.cur ||
            out_accepted !== e.acc || out_last !== e.last) begin
          errors++;
          $display("%0t: mismatch exp idx=%0d cur=%h acc=%b last=%b",
                   $time, e.idx, e.cur, e.acc, e.last,
                   " act idx=%0d cur=%h acc=%b last=%b",
                   out_neuron_index, out_total_current, out_accepted, out_last);
        end
      end
    end
  end

  // drive one word, with a random gap at burst boundaries
  task automatic send_word(syn_item_t it);
    int gap;
    bit ok;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_action <= it.act;
    in_spike_mask <= it.mask;
    in_pre_index <= it.pre;
    in_post_index <= it.post;
    in_weight_value <= it.wgt;
    in_decay_tau <= it.tau;
    in_bias_value <= it.bias;
    do @(posedge clk); while (in_stall);
    ok = predict_reports(it);
    if (it.chk && ok != it.acc) begin
      errors++;
      $display("%0t: table accept exp=%b model=%b", $time, it.acc, ok);
    end
  endtask

  // idle the sender, drain, then write the neuron count
  task automatic set_count(logic [CNT_W-1:0] v);
    in_valid <= 1'b0;
    wait (report_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    mdl_count = v;
  endtask

  function automatic logic [TAU_W-1:0] pick_tau();
    case ($urandom_range(0, 7))
      0: return 16'd0;
      1: return 16'd1;
      2: return 16'd2;
      3: return 16'hFFFF;
      4, 5: return TAU_W'($urandom_range(2, 12));
      default: return TAU_W'($urandom);
    endcase
  endfunction

  function automatic syn_item_t rand_word();
    syn_item_t it;
    int unsigned n;
    int k;
    n = active_n();
    k = $urandom_range(0, 99);
    it.act = (k < 30) ? ACT_TICK : (k < 70) ? ACT_LOAD : (k < 85) ? ACT_UPDATE : ACT_BIAS;
    it.mask = {$urandom, $urandom};
    it.pre = ($urandom_range(0, 6) == 0) ? IDX_W'($urandom)
                                          : IDX_W'($urandom_range(0, n - 1));
    it.post = ($urandom_range(0, 6) == 0) ? IDX_W'($urandom)
                                           : IDX_W'($urandom_range(0, n - 1));
    case ($urandom_range(0, 5))
      0: it.wgt = 24'h7FFFFF;
      1: it.wgt = 24'h800000;
      default: it.wgt = WGT_W'($urandom);
    endcase
    it.tau = pick_tau();
    case ($urandom_range(0, 5))
      0: it.bias = 32'h7FFFFFFF;
      1: it.bias = 32'h80000000;
      default: it.bias = $urandom;
    endcase
    it.chk = 1'b0;
    it.acc = 1'b0;
    return it;
  endfunction

  syn_item_t dir_tab[14];
  logic [CNT_W-1:0] phase_counts[8] = '{7'd1, 7'd5, 7'd24, 7'd0, 7'd100, 7'd3, 7'd127, 7'd64};

  initial begin
    errors = 0;
    cycles = 0;
    burst_left = 0;
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_action = '0;
    in_spike_mask = '0;
    in_pre_index = '0;
    in_post_index = '0;
    in_weight_value = '0;
    in_decay_tau = '0;
    in_bias_value = '0;
    out_stall = 1'b0;
    for (int a = 0; a < NMAX*NMAX; a++) begin
      mdl_cur[a] = 0; mdl_wgt[a] = 0; mdl_tau[a] = 1; mdl_conn[a] = 0;
    end
    for (int j = 0; j < NMAX; j++) mdl_bias[j] = 0;
    mdl_count = NCOUNT_RST;

    //           act         mask           pre    post   wgt         tau       bias     chk acc
    dir_tab[0]  = '{ACT_TICK,   64'h0,        6'd0,  6'd0,  24'h0,      16'd0,    32'h0, 1, 1};
    dir_tab[1]  = '{ACT_LOAD,   64'h0,        6'd0,  6'd1,  24'h010000, 16'd0,    32'h0, 1, 0};
    dir_tab[2]  = '{ACT_LOAD,   64'h0,        6'd63, 6'd63, 24'h7FFFFF, 16'd1,    32'h0, 1, 1};
    dir_tab[3]  = '{ACT_UPDATE, 64'h0,        6'd63, 6'd63, 24'h7FFFFF, 16'd1,    32'h0, 1, 0};
    dir_tab[4]  = '{ACT_UPDATE, 64'h0,        6'd63, 6'd63, 24'h7FFFFF, 16'd2,    32'h0, 1, 1};
    dir_tab[5]  = '{ACT_LOAD,   64'h0,        6'd0,  6'd63, 24'h800000, 16'hFFFF, 32'h0, 1, 1};
    dir_tab[6]  = '{ACT_LOAD,   64'h0,        6'd0,  6'd63, 24'h800000, 16'hFFFF, 32'h0, 1, 1};
    dir_tab[7]  = '{ACT_UPDATE, 64'h0,        6'd5,  6'd7,  24'h000100, 16'd3,    32'h0, 1, 1};
    dir_tab[8]  = '{ACT_BIAS,   64'h0,        6'd0,  6'd63, 24'h0,      16'd0, 32'h7FFFFFFF, 1, 1};
    dir_tab[9]  = '{ACT_BIAS,   64'h0,        6'd0,  6'd0,  24'h0,      16'd0, 32'h80000000, 1, 1};
    dir_tab[10] = '{ACT_TICK,   {64{1'b1}},   6'd0,  6'd0,  24'h0,      16'd0,    32'h0, 1, 1};
    dir_tab[11] = '{ACT_LOAD,   64'h0,        6'd5,  6'd7,  24'h123456, 16'd4,    32'h0, 1, 1};
    dir_tab[12] = '{ACT_TICK,   64'h8000000000000021, 6'd0, 6'd0, 24'h0, 16'd0,  32'h0, 1, 1};
    dir_tab[13] = '{ACT_TICK,   64'h0,        6'd0,  6'd0,  24'h0,      16'd0,    32'h0, 1, 1};

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed table at the reset neuron count
    foreach (dir_tab[r]) send_word(dir_tab[r]);

    // random words over a range of neuron counts
    foreach (phase_counts[p]) begin
      set_count(phase_counts[p]);
      for (int k = 0; k < 13; k++) send_word(rand_word());
    end

    in_valid <= 1'b0;
    wait (report_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* spike_synapse_current_engine_core.f */
src/ssce_pkg.sv
src/ssce_ram.sv
src/ssce_div.sv
src/spike_synapse_current_engine_core.sv
tb/sv/spike_synapse_current_engine_core_test.sv
